>>> src/tbt_pkg.sv
// Package for the token bucket table: defaults, field widths, kind and status codes.
package tbt_pkg;

    // Default sizing
    localparam int NUM_BUCKETS_DEF = 64;
    localparam int TOKEN_BITS_DEF  = 16;

    // Fixed port field widths
    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        K_TICK    = 3'd0,
        K_CREATE  = 3'd1,
        K_FETCH   = 3'd2,
        K_RETURN  = 3'd3,
        K_DESTROY = 3'd4
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

endpackage

>>> src/tbt_cell.sv
// One bucket of the table: holds its state and acts on the command word passing by.
module tbt_cell
    import tbt_pkg::*;
#(
    parameter int TB  = TOKEN_BITS_DEF,
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [3*TB+STATUS_W+2*SLOT_W+KIND_W+1+1+TB-1:0] i_tok,
    output logic [3*TB+STATUS_W+2*SLOT_W+KIND_W+1+1+TB-1:0] o_tok
);

    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [TB-1:0]     amount;
        logic [TB-1:0]     rate;
        logic [TB-1:0]     burst;
        logic              done;
        t_status           status;
        logic [SLOT_W-1:0] slot_out;
        logic [TB-1:0]     granted;
    } t_tok;

    t_tok          w_in;
    t_tok          r_tok, n_tok;
    logic          r_valid, n_valid;
    logic [TB-1:0] r_rate, n_rate;
    logic [TB-1:0] r_cap, n_cap;
    logic [TB-1:0] r_tokens, n_tokens;
    logic          w_hit;
    logic [TB:0]   w_tick_sum;
    logic [TB:0]   w_ret_sum;

    assign w_in  = t_tok'(i_tok);
    assign o_tok = r_tok;

    // slot addresses this cell; an out-of-range slot never matches
    assign w_hit = (32'(w_in.slot) == 32'(IDX)) && r_valid;

    assign w_tick_sum = {1'b0, r_tokens} + {1'b0, r_rate};
    assign w_ret_sum  = {1'b0, r_tokens} + {1'b0, w_in.amount};

    // act on the passing word
    always_comb begin
        n_tok    = w_in;
        n_valid  = r_valid;
        n_rate   = r_rate;
        n_cap    = r_cap;
        n_tokens = r_tokens;
        if (w_in.vld) begin
            case (w_in.kind)
                K_TICK: begin
                    if (r_valid) begin
                        n_tokens = (w_tick_sum >= {1'b0, r_cap}) ? r_cap : w_tick_sum[TB-1:0];
                    end
                end
                K_CREATE: begin
                    if (!w_in.done && !r_valid) begin
                        n_valid        = 1'b1;
                        n_rate         = w_in.rate;
                        n_cap          = w_in.burst;
                        n_tokens       = '0;
                        n_tok.done     = 1'b1;
                        n_tok.status   = ST_OK;
                        n_tok.slot_out = SLOT_W'(IDX);
                    end
                end
                K_FETCH: begin
                    if (w_hit && (w_in.amount != '0)) begin
                        if (r_tokens == '0) begin
                            n_tok.status = ST_EMPTY;
                        end else if (r_tokens < w_in.amount) begin
                            n_tok.status  = ST_OK;
                            n_tok.granted = r_tokens;
                            n_tokens      = '0;
                        end else begin
                            n_tok.status  = ST_OK;
                            n_tok.granted = w_in.amount;
                            n_tokens      = r_tokens - w_in.amount;
                        end
                    end
                end
                K_RETURN: begin
                    if (w_hit && (w_in.amount != '0)) begin
                        n_tok.status = ST_OK;
                        n_tokens = (w_ret_sum >= {1'b0, r_cap}) ? r_cap : w_ret_sum[TB-1:0];
                    end
                end
                K_DESTROY: begin
                    if (w_hit) begin
                        n_tok.status = ST_OK;
                        n_valid      = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_tok.vld <= n_tok.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rate         <= n_rate;
        r_cap          <= n_cap;
        r_tokens       <= n_tokens;
        r_tok.kind     <= n_tok.kind;
        r_tok.slot     <= n_tok.slot;
        r_tok.amount   <= n_tok.amount;
        r_tok.rate     <= n_tok.rate;
        r_tok.burst    <= n_tok.burst;
        r_tok.done     <= n_tok.done;
        r_tok.status   <= n_tok.status;
        r_tok.slot_out <= n_tok.slot_out;
        r_tok.granted  <= n_tok.granted;
    end

endmodule

>>> src/token_bucket_table.sv
// Token bucket table: a row of bucket cells that a command word walks through.
//
// Usage: present kind, slot, amount, rate and burst size with start high; the
// word is taken at a rising edge where start is high and busy is low. busy
// then stays high until the result has been shown.
// The command word enters an entry register and then passes one bucket cell
// per clock, each cell updating its own bucket as the word goes by; the lowest
// free slot for a create is the first free cell the word meets.
// The result appears once the word has left the last cell, on o_status,
// o_slot_out and o_granted, with o_done high for exactly one cycle. busy
// falls the cycle after; only then is a new item taken, and every kind
// walks the whole cell row.
// The receiver cannot stall: each result word must be taken while o_done is high.
// Reset clears all valid marks and any item in flight; bucket contents are
// only read after a create has written them.
module token_bucket_table
    import tbt_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int TOKEN_BITS  = TOKEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [AMOUNT_W-1:0] i_amount,
    input  logic [AMOUNT_W-1:0] i_rate,
    input  logic [AMOUNT_W-1:0] i_burst_size,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_out,
    output logic [AMOUNT_W-1:0] o_granted
);

    localparam int TB    = TOKEN_BITS;
    localparam int TOK_W = 3*TB + STATUS_W + 2*SLOT_W + KIND_W + 1 + 1 + TB;

    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [TB-1:0]     amount;
        logic [TB-1:0]     rate;
        logic [TB-1:0]     burst;
        logic              done;
        t_status           status;
        logic [SLOT_W-1:0] slot_out;
        logic [TB-1:0]     granted;
    } t_tok;

    t_tok             r_entry, n_entry;
    logic             r_busy, n_busy;
    logic             w_accept;
    logic [TOK_W-1:0] w_chain [NUM_BUCKETS+1];
    t_tok             w_last;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    // build the command word, status preset to what holds if no cell acts
    always_comb begin
        n_entry          = r_entry;
        n_entry.vld      = w_accept;
        if (w_accept) begin
            n_entry.kind     = t_kind'(i_kind);
            n_entry.slot     = i_slot;
            n_entry.amount   = TB'(i_amount);
            n_entry.rate     = TB'(i_rate);
            n_entry.burst    = TB'(i_burst_size);
            n_entry.done     = 1'b0;
            n_entry.slot_out = i_slot;
            n_entry.granted  = '0;
            case (t_kind'(i_kind))
                K_TICK:   n_entry.status = ST_OK;
                K_CREATE: n_entry.status = ST_FULL;
                default:  n_entry.status = ST_BAD;
            endcase
        end
    end

    // busy from accept until the word leaves the last cell
    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_last.vld) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_entry.vld <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_entry.vld <= n_entry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.kind     <= n_entry.kind;
        r_entry.slot     <= n_entry.slot;
        r_entry.amount   <= n_entry.amount;
        r_entry.rate     <= n_entry.rate;
        r_entry.burst    <= n_entry.burst;
        r_entry.done     <= n_entry.done;
        r_entry.status   <= n_entry.status;
        r_entry.slot_out <= n_entry.slot_out;
        r_entry.granted  <= n_entry.granted;
    end

    // row of bucket cells
    assign w_chain[0] = r_entry;

    for (genvar g = 0; g < NUM_BUCKETS; g++) begin : g_cell
        tbt_cell #(
            .TB  (TB),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1])
        );
    end

    // result word straight from the last cell's register
    assign w_last     = t_tok'(w_chain[NUM_BUCKETS]);
    assign o_done     = w_last.vld;
    assign o_status   = w_last.status;
    assign o_slot_out = w_last.slot_out;
    assign o_granted  = AMOUNT_W'(w_last.granted);

endmodule

>>> src/tbt_checker.sv
// Port-level checker for the token bucket table, with its bind.
module tbt_checker
    import tbt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input logic [STATUS_W-1:0] o_status,
    input logic [AMOUNT_W-1:0] o_granted
);

    // a result only comes out of an accepted item
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result word without an item in flight");

    // accepted word holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // one result per item
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle or busy stuck");

    // tokens granted only with ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_granted != '0)) |-> (o_status == ST_OK))
        else $error("tokens granted with a failing status");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("block not idle after reset");

endmodule

bind token_bucket_table tbt_checker u_tbt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_status  (o_status),
    .o_granted (o_granted)
);
